/* sv/asrl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package asrl_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned StepW = 33;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RISING_RATE  = 2'd0,
    CFG_FALLING_RATE = 2'd1,
    CFG_RANGE_LO     = 2'd2,
    CFG_RANGE_HI     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_INIT = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  localparam logic [DataW-1:0] RISING_RATE_RST  = 32'h0001_0000;
  localparam logic [DataW-1:0] FALLING_RATE_RST = 32'h0001_0000;
  localparam logic [DataW-1:0] RANGE_LO_RST     = 32'hFFFF_0000;
  localparam logic [DataW-1:0] RANGE_HI_RST     = 32'h0001_0000;

  typedef struct packed {
    logic                    req_type;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] delta_time;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] output_value;
    status_e                 status;
  } out_item_t;

  typedef struct packed {
    logic        [DataW-1:0] rising_rate;
    logic        [DataW-1:0] falling_rate;
    logic signed [DataW-1:0] range_lo;
    logic signed [DataW-1:0] range_hi;
  } cfg_t;

  typedef struct packed {
    logic signed [DataW-1:0] held_d;
    logic                    loaded_d;
    status_e                 status;
  } step_res_t;

endpackage
`default_nettype wire

/* sv/asrl_step.sv */
`timescale 1ns / 1ps
`default_nettype none
module asrl_step import asrl_pkg::*; (
  input  in_item_t                item_i,
  input  logic [StepW-1:0]        step_rise_i,
  input  logic [StepW-1:0]        step_fall_i,
  input  logic signed [DataW-1:0] held_i,
  input  logic                    loaded_i,
  input  cfg_t                    cfg_i,
  output step_res_t               res_o
);

  logic signed [DataW-1:0] val;
  logic signed [DataW-1:0] dt;
  logic signed [DataW-1:0] omin;
  logic signed [DataW-1:0] omax;
  logic signed [DataW-1:0] held;
  logic signed [DataW-1:0] target;
  logic signed [DataW:0]   diff;
  logic        [DataW:0]   mag;
  logic        [StepW-1:0] step;
  logic        [DataW+1:0] moved;
  logic                    cfg_ok;
  logic                    dt_pos;
  logic                    in_range;

  assign val  = item_i.value;
  assign dt   = item_i.delta_time;
  assign omin = cfg_i.range_lo;
  assign omax = cfg_i.range_hi;
  assign held = held_i;

  assign cfg_ok = (cfg_i.rising_rate != '0) && (cfg_i.falling_rate != '0) && (omin < omax);
  assign dt_pos = !dt[DataW-1] && (dt != '0);
  assign in_range = (val >= omin) && (val <= omax);

  always_comb begin
    priority if (val < omin) begin
      target = omin;
    end else if (val > omax) begin
      target = omax;
    end else begin
      target = val;
    end
  end

  assign diff = {target[DataW-1], target} - {held[DataW-1], held};
  assign mag  = diff[DataW] ? (DataW+1)'(-diff) : diff;
  assign step = diff[DataW] ? step_fall_i : step_rise_i;
  assign moved = diff[DataW] ? ({{2{held[DataW-1]}}, held} - {1'b0, step})
                             : ({{2{held[DataW-1]}}, held} + {1'b0, step});

  always_comb begin
    res_o.held_d   = held_i;
    res_o.loaded_d = loaded_i;
    res_o.status   = ST_OK;
    priority if (item_i.req_type == REQ_LOAD) begin
      if (!cfg_ok || !in_range) begin
        res_o.status = ST_RANGE;
      end else begin
        res_o.held_d   = val;
        res_o.loaded_d = 1'b1;
      end
    end else if (!loaded_i) begin
      res_o.status = ST_NOT_INIT;
    end else if (!cfg_ok || !dt_pos) begin
      res_o.status = ST_RANGE;
    end else if (mag <= step) begin
      res_o.held_d = target;
    end else begin
      res_o.held_d = moved[DataW-1:0];
    end
  end

endmodule
`default_nettype wire

/* sv/asymmetric_slew_rate_limiter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// asymmetric slew-rate limiter, signed q16.16
// input channel in_valid_i / in_stall_o carries one request per transfer:
//   req_type 0 steps the output toward value by at most rate * delta_time,
//   req_type 1 loads value as the output when it lies in range
// output channel out_valid_o / out_stall_i carries one result per request:
//   the held output after the request and a status code
// config port: cfg_we_i writes cfg_data_i to register cfg_idx_i;
//   write only while no request is in flight
// a request passes the first stage and the result register before it is offered
// throughput: one request per cycle while the output is not stalled; the first
//   stage computes both rate products (one 32x31 multiplier each), the second
//   applies the clamp, the step compare and the held-output update
// a stalled result holds its register; the input stage keeps taking requests
//   while it is empty, then stalls in turn
// reset clears the pipeline, the held output (zero), the loaded flag and
//   restores the default config: rates 1.0, range -1.0 to 1.0
module asymmetric_slew_rate_limiter_top import asrl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  cfg_t                    cfg_q;
  logic                    s1_valid_q;
  in_item_t                s1_item_q;
  logic [StepW-1:0]        s1_rise_q;
  logic [StepW-1:0]        s1_fall_q;
  logic                    out_valid_q;
  out_item_t               out_q;
  logic signed [DataW-1:0] held_q;
  logic                    loaded_q;

  logic                    out_adv;
  logic                    s1_adv;
  logic                    in_acc;
  logic [2*DataW-2:0]      prod_rise;
  logic [2*DataW-2:0]      prod_fall;
  logic [StepW-1:0]        step_rise_d;
  logic [StepW-1:0]        step_fall_d;
  step_res_t               res;

  // handshake
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_adv;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rising_rate  <= RISING_RATE_RST;
      cfg_q.falling_rate <= FALLING_RATE_RST;
      cfg_q.range_lo     <= RANGE_LO_RST;
      cfg_q.range_hi     <= RANGE_HI_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RISING_RATE:  cfg_q.rising_rate  <= cfg_data_i;
        CFG_FALLING_RATE: cfg_q.falling_rate <= cfg_data_i;
        CFG_RANGE_LO:     cfg_q.range_lo     <= cfg_data_i;
        CFG_RANGE_HI:     cfg_q.range_hi     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // rate times dt, floor q16.16, saturated to the step width
  assign prod_rise = (2*DataW-1)'(cfg_q.rising_rate) *
                     (2*DataW-1)'(in_data_i.delta_time[DataW-2:0]);
  assign prod_fall = (2*DataW-1)'(cfg_q.falling_rate) *
                     (2*DataW-1)'(in_data_i.delta_time[DataW-2:0]);
  assign step_rise_d = (|prod_rise[2*DataW-2:StepW+16]) ? '1 : prod_rise[StepW+15:16];
  assign step_fall_d = (|prod_fall[2*DataW-2:StepW+16]) ? '1 : prod_fall[StepW+15:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_data_i;
      s1_rise_q <= step_rise_d;
      s1_fall_q <= step_fall_d;
    end
  end

  asrl_step u_step (
    .item_i      (s1_item_q),
    .step_rise_i (s1_rise_q),
    .step_fall_i (s1_fall_q),
    .held_i      (held_q),
    .loaded_i    (loaded_q),
    .cfg_i       (cfg_q),
    .res_o       (res)
  );

  // limiter state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      loaded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        held_q   <= res.held_d;
        loaded_q <= res.loaded_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.output_value <= res.held_d;
      out_q.status       <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.output_value == held_q))
    else $error("result differs from held output");

  a_not_init_unloaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_NOT_INIT) |-> !loaded_q)
    else $error("not-initialized status while loaded");

  a_loaded_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(loaded_q))
    else $error("loaded flag cleared");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty stage");

endmodule
`default_nettype wire
